@@ hdl/srsw_pkg.sv @@
package srsw_pkg;

	// Input opcodes.
	localparam logic [1:0] OP_START = 2'd0;
	localparam logic [1:0] OP_ACK   = 2'd1;
	localparam logic [1:0] OP_TICK  = 2'd2;

	// Configuration register indexes.
	localparam logic [1:0] CFG_WIN_SIZE = 2'd0;
	localparam logic [1:0] CFG_TIMEOUT  = 2'd1;
	localparam logic [1:0] CFG_TOTAL    = 2'd2;

	// Configuration reset values.
	localparam logic [4:0]  WIN_SIZE_RST = 5'd8;
	localparam logic [15:0] TIMEOUT_RST  = 16'd500;
	localparam logic [31:0] TOTAL_RST    = 32'd0;

	localparam logic [15:0] AGE_MAX = 16'hFFFF;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic init_start;
		logic ack_in;
		logic start_step;
		logic slide_step;
		logic tick_step;
		logic flush;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic out_free;
		logic start_more;
		logic slide_go;
		logic tick_last;
		logic cnt_zero;
	} sts_t;

endpackage

@@ hdl/srsw_if.sv @@
interface srsw_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  opcode;
	logic [31:0] ack_seq;

	modport source (output valid, opcode, ack_seq, input ready);
	modport sink (input valid, opcode, ack_seq, output ready);
endinterface

interface srsw_rsp_if;
	logic        valid;
	logic        ready;
	logic        send_valid;
	logic [31:0] send_seq;
	logic        is_resend;
	logic        all_acked;
	logic        last;

	modport source (output valid, send_valid, send_seq, is_resend, all_acked, last, input ready);
	modport sink (input valid, send_valid, send_seq, is_resend, all_acked, last, output ready);
endinterface

@@ hdl/selective_repeat_sender_window.sv @@
// Sender window of a selective-repeat ARQ link, handling sequence numbers only. Each request
// beat (start, acknowledgement, tick) yields one or more response beats, the final one flagged
// by last; a beat with send_valid set orders packet send_seq out, is_resend telling a timeout
// retransmission from a first send, and all_acked reports the window state after the request
// is done. One request is handled at a time and req.ready is high only while the block is
// idle. A start steps through min(window, total_chunks) entries, an acknowledgement through
// the slots the window slides, and a tick on an open window through all WINDOW_MAX entries,
// because the window entries live in a shift line that moves one entry per cycle, while the
// response register has room, past a single age and timeout unit; a tick on an empty window
// or an unused opcode steps no entry. Every response beat that waits on rsp.ready stalls the
// walk for as long as it waits. Configuration writes land on the clock edge where cfg_we is
// high and are to be made only while the block is idle.
module selective_repeat_sender_window #(
	parameter int WINDOW_MAX = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data,
	srsw_req_if.sink    req,
	srsw_rsp_if.source  rsp
);

	srsw_pkg::cmd_t cmd;
	srsw_pkg::sts_t sts;

	// The controller sequences each request: it takes the beat, then steps the
	// datapath one window entry per cycle while the response register has room,
	// and finally issues a flush that emits the closing beat.
	srsw_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req.valid),
		.req_opcode (req.opcode),
		.req_ready  (req.ready),
		.sts        (sts),
		.cmd        (cmd)
	);

	// The datapath holds the configuration, the window pointers, the entry
	// marks and ages, and a one-deep holding register in front of the response
	// register. Holding each send back by one step lets the block tell whether
	// it is the final beat of its request.
	srsw_dp #(
		.WINDOW_MAX (WINDOW_MAX)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.ack_seq   (req.ack_seq),
		.cmd       (cmd),
		.sts       (sts),
		.rsp       (rsp)
	);

endmodule

@@ hdl/srsw_ctrl.sv @@
module srsw_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	input  logic [1:0]        req_opcode,
	output logic              req_ready,
	input  srsw_pkg::sts_t    sts,
	output srsw_pkg::cmd_t    cmd
);

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_START = 3'd1;
	localparam logic [2:0] S_SLIDE = 3'd2;
	localparam logic [2:0] S_TICK  = 3'd3;
	localparam logic [2:0] S_FLUSH = 3'd4;

	logic [2:0] state_q;
	logic [2:0] state_d;

	assign req_ready = (state_q == S_IDLE);

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					case (req_opcode)
						srsw_pkg::OP_START: begin
							cmd.init_start = 1'b1;
							state_d        = S_START;
						end
						srsw_pkg::OP_ACK: begin
							cmd.ack_in = 1'b1;
							state_d    = S_SLIDE;
						end
						srsw_pkg::OP_TICK: begin
							state_d = sts.cnt_zero ? S_FLUSH : S_TICK;
						end
						default: begin
							state_d = S_FLUSH;
						end
					endcase
				end
			end
			S_START: begin
				if (sts.out_free) begin
					if (sts.start_more) begin
						cmd.start_step = 1'b1;
					end else begin
						state_d = S_FLUSH;
					end
				end
			end
			S_SLIDE: begin
				if (sts.out_free) begin
					if (sts.slide_go) begin
						cmd.slide_step = 1'b1;
					end else begin
						state_d = S_FLUSH;
					end
				end
			end
			S_TICK: begin
				if (sts.out_free) begin
					cmd.tick_step = 1'b1;
					if (sts.tick_last) begin
						state_d = S_FLUSH;
					end
				end
			end
			S_FLUSH: begin
				if (sts.out_free) begin
					cmd.flush = 1'b1;
					state_d   = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

@@ hdl/srsw_dp.sv @@
module srsw_dp #(
	parameter int WINDOW_MAX = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [1:0]        cfg_index,
	input  logic [31:0]       cfg_data,
	input  logic [31:0]       ack_seq,
	input  srsw_pkg::cmd_t    cmd,
	output srsw_pkg::sts_t    sts,
	srsw_rsp_if.source        rsp
);

	localparam int CW = $clog2(WINDOW_MAX + 1);
	localparam int KW = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
	localparam logic [CW-1:0] WMAX_C = CW'(WINDOW_MAX);
	localparam logic [KW-1:0] K_LAST = KW'(WINDOW_MAX - 1);

	logic [4:0]    win_size_q;
	logic [15:0]   timeout_q;
	logic [31:0]   total_q;

	logic [31:0]   base_q;
	logic [31:0]   next_q;
	logic [CW-1:0] cnt_q;
	logic [CW-1:0] first_q;
	logic [KW-1:0] k_q;
	logic          active_q;

	logic          marks_q [WINDOW_MAX];
	logic [15:0]   age_q   [WINDOW_MAX];
	logic          marks_d [WINDOW_MAX];
	logic [15:0]   age_d   [WINDOW_MAX];

	logic          pend_v_q;
	logic [31:0]   pend_seq_q;
	logic          pend_rs_q;

	logic          out_v_q;
	logic          out_send_q;
	logic [31:0]   out_seq_q;
	logic          out_rs_q;
	logic          out_all_q;
	logic          out_last_q;

	logic [CW-1:0] w_eff;
	logic [CW-1:0] first_c;
	logic [CW-1:0] ins_idx;
	logic [31:0]   ack_dist;
	logic          ack_hit;
	logic          fresh;
	logic [15:0]   age0_inc;
	logic [15:0]   age0_new;
	logic          tick_live;
	logic          tick_fire;
	logic          ev_valid;
	logic [31:0]   ev_seq;
	logic          ev_rs;
	logic          load_mid;

	// Effective window: zero counts as one, anything above the storage depth is clamped.
	always_comb begin
		if (win_size_q == '0) begin
			w_eff = CW'(1);
		end else if (32'(win_size_q) > 32'(WINDOW_MAX)) begin
			w_eff = WMAX_C;
		end else begin
			w_eff = CW'(win_size_q);
		end
	end

	assign first_c   = (total_q < 32'(w_eff)) ? total_q[CW-1:0] : w_eff;
	assign ack_dist  = ack_seq - base_q;
	assign ack_hit   = cmd.ack_in && (ack_dist < 32'(cnt_q));
	assign fresh     = (cnt_q <= w_eff) && (next_q < total_q);
	assign ins_idx   = cnt_q - CW'(1);
	assign age0_inc  = (age_q[0] == srsw_pkg::AGE_MAX) ? age_q[0] : age_q[0] + 16'd1;
	assign tick_live = (CW'(k_q) < cnt_q) && !marks_q[0];
	assign tick_fire = tick_live && (age0_inc >= timeout_q);
	assign age0_new  = tick_live ? (tick_fire ? 16'd0 : age0_inc) : age_q[0];

	// Window entries sit in a shift line. A slide drops the front entry; a tick pass
	// rotates the whole line once so that every entry is aged at the front position.
	always_comb begin
		for (int i = 0; i < WINDOW_MAX; i++) begin
			marks_d[i] = marks_q[i];
			age_d[i]   = age_q[i];
		end
		if (cmd.init_start) begin
			for (int i = 0; i < WINDOW_MAX; i++) begin
				marks_d[i] = 1'b0;
				age_d[i]   = 16'd0;
			end
		end else if (ack_hit) begin
			for (int i = 0; i < WINDOW_MAX; i++) begin
				if (ack_dist[KW-1:0] == KW'(i)) begin
					marks_d[i] = 1'b1;
				end
			end
		end else if (cmd.slide_step) begin
			for (int i = 0; i < WINDOW_MAX - 1; i++) begin
				marks_d[i] = marks_q[i+1];
				age_d[i]   = age_q[i+1];
			end
			marks_d[WINDOW_MAX-1] = 1'b0;
			age_d[WINDOW_MAX-1]   = 16'd0;
			for (int i = 0; i < WINDOW_MAX; i++) begin
				if (fresh && (CW'(i) == ins_idx)) begin
					marks_d[i] = 1'b0;
					age_d[i]   = 16'd0;
				end
			end
		end else if (cmd.tick_step) begin
			for (int i = 0; i < WINDOW_MAX - 1; i++) begin
				marks_d[i] = marks_q[i+1];
				age_d[i]   = age_q[i+1];
			end
			marks_d[WINDOW_MAX-1] = marks_q[0];
			age_d[WINDOW_MAX-1]   = age0_new;
		end
	end

	always_comb begin
		ev_valid = 1'b0;
		ev_seq   = next_q;
		ev_rs    = 1'b0;
		if (cmd.start_step) begin
			ev_valid = 1'b1;
		end else if (cmd.slide_step) begin
			ev_valid = fresh;
		end else if (cmd.tick_step) begin
			ev_valid = tick_fire;
			ev_seq   = base_q + 32'(k_q);
			ev_rs    = 1'b1;
		end
	end

	assign load_mid = ev_valid && pend_v_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_size_q <= srsw_pkg::WIN_SIZE_RST;
			timeout_q  <= srsw_pkg::TIMEOUT_RST;
			total_q    <= srsw_pkg::TOTAL_RST;
			base_q     <= '0;
			next_q     <= '0;
			cnt_q      <= '0;
			first_q    <= '0;
			k_q        <= '0;
			active_q   <= 1'b0;
			pend_v_q   <= 1'b0;
			out_v_q    <= 1'b0;
			for (int i = 0; i < WINDOW_MAX; i++) begin
				marks_q[i] <= 1'b0;
				age_q[i]   <= 16'd0;
			end
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					srsw_pkg::CFG_WIN_SIZE: win_size_q <= cfg_data[4:0];
					srsw_pkg::CFG_TIMEOUT:  timeout_q  <= cfg_data[15:0];
					srsw_pkg::CFG_TOTAL:    total_q    <= cfg_data;
					default: ;
				endcase
			end
			for (int i = 0; i < WINDOW_MAX; i++) begin
				marks_q[i] <= marks_d[i];
				age_q[i]   <= age_d[i];
			end
			if (cmd.init_start) begin
				base_q   <= '0;
				next_q   <= '0;
				cnt_q    <= '0;
				first_q  <= first_c;
				active_q <= 1'b1;
			end
			if (cmd.start_step) begin
				next_q <= next_q + 32'd1;
				cnt_q  <= cnt_q + CW'(1);
			end
			if (cmd.slide_step) begin
				base_q <= base_q + 32'd1;
				if (fresh) begin
					next_q <= next_q + 32'd1;
				end else begin
					cnt_q <= cnt_q - CW'(1);
				end
			end
			if (cmd.tick_step) begin
				k_q <= (k_q == K_LAST) ? '0 : k_q + KW'(1);
			end
			if (ev_valid) begin
				pend_v_q <= 1'b1;
			end else if (cmd.flush) begin
				pend_v_q <= 1'b0;
			end
			if (load_mid || cmd.flush) begin
				out_v_q <= 1'b1;
			end else if (rsp.ready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ev_valid) begin
			pend_seq_q <= ev_seq;
			pend_rs_q  <= ev_rs;
		end
		// A send that is followed by another one never ends with an empty window,
		// so its all_acked is zero.
		if (load_mid) begin
			out_send_q <= 1'b1;
			out_seq_q  <= pend_seq_q;
			out_rs_q   <= pend_rs_q;
			out_all_q  <= 1'b0;
			out_last_q <= 1'b0;
		end else if (cmd.flush) begin
			out_send_q <= pend_v_q;
			out_seq_q  <= pend_v_q ? pend_seq_q : 32'd0;
			out_rs_q   <= pend_v_q && pend_rs_q;
			out_all_q  <= active_q && (cnt_q == '0);
			out_last_q <= 1'b1;
		end
	end

	assign sts.out_free   = !out_v_q || rsp.ready;
	assign sts.start_more = (cnt_q < first_q);
	assign sts.slide_go   = (cnt_q != '0) && marks_q[0];
	assign sts.tick_last  = (k_q == K_LAST);
	assign sts.cnt_zero   = (cnt_q == '0);

	assign rsp.valid      = out_v_q;
	assign rsp.send_valid = out_send_q;
	assign rsp.send_seq   = out_seq_q;
	assign rsp.is_resend  = out_rs_q;
	assign rsp.all_acked  = out_all_q;
	assign rsp.last       = out_last_q;

endmodule

@@ hdl/srsw_chk.sv @@
module srsw_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        req_valid,
	input logic        req_ready,
	input logic        rsp_valid,
	input logic        rsp_ready,
	input logic        rsp_send_valid,
	input logic [31:0] rsp_send_seq,
	input logic        rsp_is_resend,
	input logic        rsp_all_acked,
	input logic        rsp_last
);

	// A send beat always leaves at least one packet outstanding.
	a_send_not_done: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_send_valid |-> !rsp_all_acked)
	else $error("send beat reports all packets acknowledged");

	// A beat without a send is only ever the single closing beat of a request.
	a_idle_beat_form: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_send_valid |-> rsp_last && !rsp_is_resend && (rsp_send_seq == 32'd0))
	else $error("beat without send is malformed");

	// Once a request beat is taken, no further request is taken until it is answered.
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
	else $error("request taken while the previous one is in progress");

	// A stalled response beat holds.
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_send_valid)
			&& $stable(rsp_send_seq) && $stable(rsp_is_resend)
			&& $stable(rsp_all_acked) && $stable(rsp_last))
	else $error("stalled response beat changed");

endmodule

bind selective_repeat_sender_window srsw_chk u_chk (
	.clk            (clk),
	.arst_n         (arst_n),
	.req_valid      (req.valid),
	.req_ready      (req.ready),
	.rsp_valid      (rsp.valid),
	.rsp_ready      (rsp.ready),
	.rsp_send_valid (rsp.send_valid),
	.rsp_send_seq   (rsp.send_seq),
	.rsp_is_resend  (rsp.is_resend),
	.rsp_all_acked  (rsp.all_acked),
	.rsp_last       (rsp.last)
);
